// ===== design/ltf_pkg.sv =====
// ----------------------------------------------------------------------------
// ltf_pkg: shared types and constants of the letter trigram extractor
// Opcodes, record layout, table geometry and character classification.
// ----------------------------------------------------------------------------
package ltf_pkg;

  localparam int unsigned LETTER_COUNT = 37;
  localparam int unsigned ID_W         = 6;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned TOTAL_W      = 12;

  localparam int unsigned TABLE_ENTRIES = LETTER_COUNT * LETTER_COUNT * LETTER_COUNT;
  localparam logic [ADDR_W-1:0] TABLE_DEPTH = ADDR_W'(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0] TABLE_LAST  = ADDR_W'(TABLE_ENTRIES - 1);
  localparam int unsigned STRIDE_A = LETTER_COUNT * LETTER_COUNT;
  localparam int unsigned STRIDE_B = LETTER_COUNT;

  localparam logic [ID_W-1:0]    BOUNDARY_ID = ID_W'(36);
  localparam logic [ID_W-1:0]    DROP_ID     = ID_W'(LETTER_COUNT);
  localparam logic [DATA_W-1:0]  ABSENT_ID   = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 12'hFFF;

  // Output queue geometry: room for two in-flight requests of two records each.
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;
  localparam logic [OUT_CNT_W-1:0] OUT_ACCEPT_MAX = OUT_CNT_W'(OUT_DEPTH - 4);
  localparam logic [OUT_CNT_W-1:0] OUT_FULL       = OUT_CNT_W'(OUT_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_START = 2'd3
  } ltf_op_e;

  localparam logic REC_FEATURE = 1'b0;
  localparam logic REC_SEGMENT = 1'b1;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ltf_mem_req_t;

  typedef struct packed {
    logic probe;
    logic word_end;
    logic query_start;
  } ltf_cmd_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } ltf_rec_t;

  // Letter id of a raw byte; DROP_ID for bytes that are not kept.
  function automatic logic [ID_W-1:0] letter_id(input logic [7:0] ch);
    logic [ID_W-1:0] id;
    id = DROP_ID;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      id = ID_W'(ch - 8'h61);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      id = ID_W'(ch - 8'h30) + ID_W'(26);
    end else if (ch == 8'h23) begin
      id = BOUNDARY_ID;
    end
    return id;
  endfunction

  // a*1369 + b*37 + c; ids are at most 36 so the sum fits 16 bits.
  function automatic logic [ADDR_W-1:0] trigram_index(input logic [ID_W-1:0] a,
                                                      input logic [ID_W-1:0] b,
                                                      input logic [ID_W-1:0] c);
    logic [ADDR_W:0] sum;
    sum = (ADDR_W+1)'(a) * (ADDR_W+1)'(STRIDE_A)
        + (ADDR_W+1)'(b) * (ADDR_W+1)'(STRIDE_B)
        + (ADDR_W+1)'(c);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/ltf_in_if.sv =====
// ----------------------------------------------------------------------------
// ltf_in_if: input request channel
// Valid/ready handshake carrying one opcode with its character or table write.
// ----------------------------------------------------------------------------
interface ltf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [15:0] table_address;
  logic [15:0] table_data;

  modport source (output valid, output opcode, output char_code,
                  output table_address, output table_data, input ready);
  modport sink   (input valid, input opcode, input char_code,
                  input table_address, input table_data, output ready);
endinterface

// ===== design/ltf_out_if.sv =====
// ----------------------------------------------------------------------------
// ltf_out_if: result record channel
// Valid/ready handshake carrying one feature or segment record.
// ----------------------------------------------------------------------------
interface ltf_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] record_value;
  logic        is_last;

  modport source (output valid, output record_kind, output record_value,
                  output is_last, input ready);
  modport sink   (input valid, input record_kind, input record_value,
                  input is_last, output ready);
endinterface

// ===== design/ltf_vocab_mem.sv =====
// ----------------------------------------------------------------------------
// ltf_vocab_mem: vocabulary table memory
// Single-port synchronous RAM with registered read data; fills itself with the
// absent code after reset.
// ----------------------------------------------------------------------------
module ltf_vocab_mem (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ltf_pkg::ltf_mem_req_t              req_i,
  output logic [ltf_pkg::DATA_W-1:0]         rdata_o,
  output logic                               busy_o
);

  logic [ltf_pkg::DATA_W-1:0] mem [ltf_pkg::TABLE_ENTRIES];
  logic [ltf_pkg::DATA_W-1:0] rdata_q;
  logic                       clr_busy_q, clr_busy_d;
  logic [ltf_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == ltf_pkg::TABLE_LAST) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= ltf_pkg::ABSENT_ID;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

  // Sweep walks the table one entry per cycle.
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q && clr_addr_q != ltf_pkg::TABLE_LAST |=>
      clr_busy_q && clr_addr_q == $past(clr_addr_q) + 1'b1)
    else $error("clear sweep skipped an entry");

endmodule

// ===== design/ltf_front.sv =====
// ----------------------------------------------------------------------------
// ltf_front: character parser and table address generation
// Tracks the word window, issues table writes and trigram reads, and tags
// each read with the command for the back end.
// ----------------------------------------------------------------------------
module ltf_front #(
  parameter int unsigned MAX_CHARS = 32,
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 char_code_i,
  input  logic [15:0]                table_address_i,
  input  logic [15:0]                table_data_i,
  output ltf_pkg::ltf_mem_req_t      mem_req_o,
  output logic                       cmd_valid_o,
  output ltf_pkg::ltf_cmd_t          cmd_o
);

  localparam int unsigned CharW  = $clog2(MAX_CHARS + 1);
  localparam int unsigned WordW  = $clog2(MAX_WORDS + 1);
  localparam logic [CharW-1:0] MaxCharsC = CharW'(MAX_CHARS);
  localparam logic [WordW-1:0] MaxWordsC = WordW'(MAX_WORDS);

  logic [ltf_pkg::ID_W-1:0] older_q, older_d;
  logic [ltf_pkg::ID_W-1:0] newer_q, newer_d;
  logic                     has_q, has_d;
  logic [CharW-1:0]         chars_q, chars_d;
  logic [WordW-1:0]         words_q, words_d;
  logic                     cmd_valid_q, cmd_valid_d;
  ltf_pkg::ltf_cmd_t        cmd_q, cmd_d;
  logic [ltf_pkg::ID_W-1:0] id;
  logic                     word_open;

  always_comb begin
    id        = ltf_pkg::letter_id(char_code_i);
    word_open = words_q < MaxWordsC;
    older_d   = older_q;
    newer_d   = newer_q;
    has_d     = has_q;
    chars_d   = chars_q;
    words_d   = words_q;
    cmd_valid_d = 1'b0;
    cmd_d     = '0;
    mem_req_o = '0;
    if (accept_i) begin
      case (ltf_pkg::ltf_op_e'(opcode_i))
        ltf_pkg::OP_WRITE: begin
          if (table_address_i < ltf_pkg::TABLE_DEPTH) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = table_address_i;
            mem_req_o.wdata = table_data_i;
          end
        end
        ltf_pkg::OP_START: begin
          older_d = ltf_pkg::BOUNDARY_ID;
          newer_d = ltf_pkg::BOUNDARY_ID;
          has_d   = 1'b0;
          chars_d = '0;
          words_d = '0;
          cmd_valid_d       = 1'b1;
          cmd_d.query_start = 1'b1;
        end
        ltf_pkg::OP_CHAR: begin
          if (word_open && chars_q < MaxCharsC) begin
            chars_d = chars_q + 1'b1;
            if (id != ltf_pkg::DROP_ID) begin
              if (has_q) begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = ltf_pkg::trigram_index(older_q, newer_q, id);
                cmd_valid_d    = 1'b1;
                cmd_d.probe    = 1'b1;
              end
              older_d = has_q ? newer_q : ltf_pkg::BOUNDARY_ID;
              newer_d = id;
              has_d   = 1'b1;
            end
          end
        end
        ltf_pkg::OP_END: begin
          if (word_open) begin
            // closing trigram; an empty word reads the all-boundary entry
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = ltf_pkg::trigram_index(older_q, newer_q,
                                                    ltf_pkg::BOUNDARY_ID);
            cmd_valid_d    = 1'b1;
            cmd_d.probe    = 1'b1;
            cmd_d.word_end = 1'b1;
            words_d = words_q + 1'b1;
            older_d = ltf_pkg::BOUNDARY_ID;
            newer_d = ltf_pkg::BOUNDARY_ID;
            has_d   = 1'b0;
            chars_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q     <= ltf_pkg::BOUNDARY_ID;
      newer_q     <= ltf_pkg::BOUNDARY_ID;
      has_q       <= 1'b0;
      chars_q     <= '0;
      words_q     <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      older_q     <= older_d;
      newer_q     <= newer_d;
      has_q       <= has_d;
      chars_q     <= chars_d;
      words_q     <= words_d;
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== design/ltf_back.sv =====
// ----------------------------------------------------------------------------
// ltf_back: hit detection and record generation
// Checks the table read, keeps the running feature count and forms up to
// two records per request.
// ----------------------------------------------------------------------------
module ltf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  ltf_pkg::ltf_cmd_t          cmd_i,
  input  logic [ltf_pkg::DATA_W-1:0] rdata_i,
  output logic [1:0]                 push_cnt_o,
  output ltf_pkg::ltf_rec_t          rec0_o,
  output ltf_pkg::ltf_rec_t          rec1_o
);

  logic [ltf_pkg::TOTAL_W-1:0] total_q, total_d, total_inc;
  logic                        word_hit_q, word_hit_d;
  logic                        hit, seg;
  ltf_pkg::ltf_rec_t           feat_rec, seg_rec;

  always_comb begin
    hit = cmd_valid_i && cmd_i.probe && (rdata_i != ltf_pkg::ABSENT_ID);
    total_inc = (hit && total_q != ltf_pkg::TOTAL_MAX) ? total_q + 1'b1 : total_q;
    seg = cmd_valid_i && cmd_i.word_end && (word_hit_q || hit);

    feat_rec.kind  = ltf_pkg::REC_FEATURE;
    feat_rec.value = rdata_i;
    feat_rec.last  = !seg;
    seg_rec.kind   = ltf_pkg::REC_SEGMENT;
    seg_rec.value  = ltf_pkg::DATA_W'(total_inc);
    seg_rec.last   = 1'b1;

    rec0_o     = hit ? feat_rec : seg_rec;
    rec1_o     = seg_rec;
    push_cnt_o = {hit && seg, hit ^ seg};

    total_d    = total_q;
    word_hit_d = word_hit_q;
    if (cmd_valid_i) begin
      if (cmd_i.query_start) begin
        total_d    = '0;
        word_hit_d = 1'b0;
      end else begin
        total_d    = total_inc;
        word_hit_d = cmd_i.word_end ? 1'b0 : (word_hit_q || hit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      word_hit_q <= 1'b0;
    end else begin
      total_q    <= total_d;
      word_hit_q <= word_hit_d;
    end
  end

  // Two records only as feature then closing segment.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_o == 2'd2 |-> rec0_o.kind == ltf_pkg::REC_FEATURE && !rec0_o.last
                           && rec1_o.kind == ltf_pkg::REC_SEGMENT && cmd_i.word_end)
    else $error("bad record pair");

endmodule

// ===== design/ltf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ltf_out_fifo: result record queue
// Takes up to two records per cycle, hands out one per cycle while ready is high.
// ----------------------------------------------------------------------------
module ltf_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_cnt_i,
  input  ltf_pkg::ltf_rec_t             rec0_i,
  input  ltf_pkg::ltf_rec_t             rec1_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ltf_pkg::ltf_rec_t             rec_o,
  output logic [ltf_pkg::OUT_CNT_W-1:0] count_o
);

  ltf_pkg::ltf_rec_t               entries [ltf_pkg::OUT_DEPTH];
  logic [ltf_pkg::OUT_PTR_W-1:0]   head_q, head_d, tail_q, tail_d, tail_nx;
  logic [ltf_pkg::OUT_CNT_W-1:0]   count_q, count_d;
  logic                            pop;

  always_comb begin
    pop     = (count_q != '0) && ready_i;
    tail_nx = tail_q + 1'b1;
    head_d  = pop ? head_q + 1'b1 : head_q;
    tail_d  = tail_q + ltf_pkg::OUT_PTR_W'(push_cnt_i);
    count_d = count_q + ltf_pkg::OUT_CNT_W'(push_cnt_i)
            - ltf_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entries[tail_q] <= rec0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entries[tail_nx] <= rec1_i;
    end
  end

  assign valid_o = count_q != '0;
  assign rec_o   = entries[head_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q + ltf_pkg::OUT_CNT_W'(push_cnt_i)) <= ltf_pkg::OUT_FULL)
    else $error("output queue overflow");

endmodule

// ===== design/letter_trigram_feature_extractor_top.sv =====
// ----------------------------------------------------------------------------
// letter_trigram_feature_extractor_top: letter trigram feature extractor
// Turns a stream of query characters into vocabulary feature ids and
// per-word segment offsets.
// ----------------------------------------------------------------------------
// Takes one request per cycle while ready is high: table writes, characters,
// ends of word and query starts. Each kept character (a-z, 0-9, '#') after the
// first of a word reads the 50653-entry vocabulary RAM once, and an end of word
// reads the closing trigram, so the single RAM port sets the rate at one request
// per clock. Records come out through the registered RAM read and then the output
// queue; ready drops while the 8-entry output queue holds more than four records.
// After reset the RAM fills itself with the absent code, one entry per cycle, and
// ready stays low until the fill is done.
// ----------------------------------------------------------------------------
module letter_trigram_feature_extractor_top #(
  parameter int unsigned MAX_CHARS = 32,
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ltf_in_if.sink    in_i,
  ltf_out_if.source out_o
);

  logic                            accept;
  logic                            mem_busy;
  ltf_pkg::ltf_mem_req_t           mem_req;
  logic [ltf_pkg::DATA_W-1:0]      mem_rdata;
  logic                            cmd_valid;
  ltf_pkg::ltf_cmd_t               cmd;
  logic [1:0]                      push_cnt;
  ltf_pkg::ltf_rec_t               rec0, rec1, out_rec;
  logic [ltf_pkg::OUT_CNT_W-1:0]   out_count;

  // Room is reserved for the request now in the back end plus this one.
  assign in_i.ready = !mem_busy && (out_count <= ltf_pkg::OUT_ACCEPT_MAX);
  assign accept     = in_i.valid && in_i.ready;

  // Stage 0: parse, word window, RAM access.
  ltf_front #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .opcode_i        (in_i.opcode),
    .char_code_i     (in_i.char_code),
    .table_address_i (in_i.table_address),
    .table_data_i    (in_i.table_data),
    .mem_req_o       (mem_req),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  ltf_vocab_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // Stage 1: read data lines up with its command.
  ltf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .rdata_i     (mem_rdata),
    .push_cnt_o  (push_cnt),
    .rec0_o      (rec0),
    .rec1_o      (rec1)
  );

  ltf_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .rec0_i     (rec0),
    .rec1_i     (rec1),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .rec_o      (out_rec),
    .count_o    (out_count)
  );

  assign out_o.record_kind  = out_rec.kind;
  assign out_o.record_value = out_rec.value;
  assign out_o.is_last      = out_rec.last;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !accept)
    else $error("request taken during table clear");

  // Every probe in the back end was issued as a RAM read in the previous cycle.
  a_probe_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd.probe |-> $past(mem_req.re))
    else $error("probe without matching table read");

endmodule
